// ===== sv/inverf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverf_pkg
// Shared formats, coefficients and helpers for the inverse error function.
// ----------------------------------------------------------------------------
package inverf_pkg;

    localparam int IN_FRAC_BITS  = 23;
    localparam int OUT_FRAC_BITS = 20;
    localparam int X_W           = 25;
    localparam int R_W           = 23;

    // working formats: Q30 central and log, Q24 tail polynomials
    localparam int Q       = 30;
    localparam int QT      = 24;
    localparam int U_SHIFT = Q - IN_FRAC_BITS;
    localparam int H_W     = 34;

    // tail front end
    localparam int K_W      = $clog2(Q + 1);
    localparam int W_W      = K_W + 1 + Q;
    localparam int SQ_SHIFT = 2 * QT - Q;
    localparam int RAD_W    = W_W + SQ_SHIFT;
    localparam int SQ_STAGES = (RAD_W + 1) / 2;
    localparam int RADP_W   = 2 * SQ_STAGES;
    localparam int Z_W      = SQ_STAGES;
    localparam int TAIL_LAT = 2 + Q + SQ_STAGES;

    // divider
    localparam int DIV_LAT = 2 + R_W;

    // region select
    localparam int CW = Q + 4;
    localparam logic [CW-1:0] CEN_LIM = CW'(7) << Q;

    localparam logic [X_W-1:0] ONE_IN = X_W'(1) << IN_FRAC_BITS;
    localparam logic signed [R_W-1:0] RMAX = {1'b0, {(R_W-1){1'b1}}};
    localparam logic signed [R_W-1:0] RMIN = {1'b1, {(R_W-1){1'b0}}};

    localparam logic [63:0] DEC_ONE = 64'd10000000000;

    // decimal constant with ten places to fixed point, rounded
    function automatic logic [63:0] qc(input logic [63:0] n, input int f);
        return (n / DEC_ONE) * (64'd1 << f)
             + (((n % DEC_ONE) * (64'd1 << f) + DEC_ONE / 2) / DEC_ONE);
    endfunction

    localparam logic signed [H_W-1:0] ONE_Q  = H_W'(1) << Q;
    localparam logic signed [H_W-1:0] ONE_QT = H_W'(1) << QT;

    localparam logic signed [H_W-1:0] A0 = H_W'(qc(64'd8862269237, Q));
    localparam logic signed [H_W-1:0] A1 = -H_W'(qc(64'd16601283962, Q));
    localparam logic signed [H_W-1:0] A2 = H_W'(qc(64'd9266186015, Q));
    localparam logic signed [H_W-1:0] A3 = -H_W'(qc(64'd1411032044, Q));
    localparam logic signed [H_W-1:0] B0 = -H_W'(qc(64'd21350538062, Q));
    localparam logic signed [H_W-1:0] B1 = H_W'(qc(64'd14606034035, Q));
    localparam logic signed [H_W-1:0] B2 = -H_W'(qc(64'd3319823981, Q));
    localparam logic signed [H_W-1:0] B3 = H_W'(qc(64'd119727062, Q));
    localparam logic signed [H_W-1:0] C0 = -H_W'(qc(64'd19942164566, QT));
    localparam logic signed [H_W-1:0] C1 = -H_W'(qc(64'd18726741635, QT));
    localparam logic signed [H_W-1:0] C2 = H_W'(qc(64'd36087466588, QT));
    localparam logic signed [H_W-1:0] C3 = H_W'(qc(64'd18236584577, QT));
    localparam logic signed [H_W-1:0] D0 = H_W'(qc(64'd37414629407, QT));
    localparam logic signed [H_W-1:0] D1 = H_W'(qc(64'd18184895256, QT));
    localparam logic [Q-1:0] LN2_Q = Q'(qc(64'd6931471806, Q));

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DOMAIN = 2'd1,
        ST_SAT    = 2'd2
    } t_status;

    typedef struct packed {
        logic    valid;
        logic    neg;
        logic    cen;
        t_status status;
    } t_side;

    // signed fixed-point product, magnitude rounded half away from zero
    function automatic logic signed [H_W-1:0] fmul(input logic signed [H_W-1:0] a,
                                                   input logic signed [H_W-1:0] b,
                                                   input int f);
        logic [H_W-1:0]   ma;
        logic [H_W-1:0]   mb;
        logic [2*H_W-1:0] p;
        logic [H_W-1:0]   r;
        ma = a[H_W-1] ? H_W'(-a) : H_W'(a);
        mb = b[H_W-1] ? H_W'(-b) : H_W'(b);
        p  = (2*H_W)'(ma) * (2*H_W)'(mb);
        p  = p + ((2*H_W)'(1) << (f - 1));
        r  = H_W'(p >> f);
        return (a[H_W-1] ^ b[H_W-1]) ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== sv/inverf_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverf_tail
// Tail argument z = sqrt(-ln((1-u)/2)): normalize, log2 by squaring, scale by
// ln2, then a digit-per-stage square root.
// ----------------------------------------------------------------------------
module inverf_tail (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [inverf_pkg::Q-1:0]      i_u,
    output logic [inverf_pkg::Z_W-1:0]    o_z
);

    localparam int Q   = inverf_pkg::Q;
    localparam int K_W = inverf_pkg::K_W;
    localparam int S   = inverf_pkg::SQ_STAGES;
    localparam int ZW  = inverf_pkg::Z_W;
    localparam int RMW = ZW + 2;

    // one squaring step: {fraction bit, next mantissa}
    function automatic logic [Q+1:0] log_step(input logic [Q:0] m);
        logic [2*Q+1:0] sq;
        logic [Q+1:0]   t;
        sq = (2*Q+2)'(m) * (2*Q+2)'(m);
        t  = sq[2*Q+1:Q];
        return t[Q+1] ? {1'b1, t[Q+1:1]} : {1'b0, t[Q:0]};
    endfunction

    logic [Q:0]   n_m0;
    logic [K_W-1:0] n_k0;

    logic [Q:0]     r_m [0:Q-1];
    logic [Q-1:0]   r_f [0:Q];
    logic [K_W-1:0] r_k [0:Q];
    logic [Q+1:0]   n_step [1:Q];

    logic [K_W:0]   n_int;
    logic [Q-1:0]   n_frac;
    logic [inverf_pkg::W_W-1:0] n_w;

    logic [inverf_pkg::RADP_W-1:0] r_rad [0:S-1];
    logic [RMW-1:0] r_rem  [0:S-1];
    logic [ZW-1:0]  r_root [0:S];
    logic [RMW+1:0] n_cur  [1:S];
    logic           n_ge   [1:S];

    // leading-zero normalize so the mantissa sits in [1,2)
    always_comb begin
        n_m0 = ((Q+1)'(1) << Q) - (Q+1)'(i_u);
        n_k0 = '0;
        for (int b = K_W - 1; b >= 0; b--) begin
            if ((n_m0 >> (Q + 1 - (1 << b))) == '0) begin
                n_m0 = n_m0 << (1 << b);
                n_k0 = n_k0 + K_W'(1 << b);
            end
        end
    end

    always_comb begin
        for (int j = 1; j <= Q; j++) begin
            n_step[j] = log_step((j == 1) ? r_m[0] : r_m[(j > 1) ? j - 1 : 0]);
        end
    end

    always_comb begin
        n_int  = (K_W+1)'(r_k[Q]) + (K_W+1)'(r_f[Q] == '0);
        n_frac = -r_f[Q];
        n_w    = inverf_pkg::W_W'(n_int) * inverf_pkg::W_W'(inverf_pkg::LN2_Q)
               + inverf_pkg::W_W'(((2*Q)'(n_frac) * (2*Q)'(inverf_pkg::LN2_Q)
                                   + ((2*Q)'(1) << (Q - 1))) >> Q);
    end

    always_comb begin
        for (int j = 1; j <= S; j++) begin
            n_cur[j] = {r_rem[j-1], r_rad[j-1][inverf_pkg::RADP_W-1 -: 2]};
            n_ge[j]  = n_cur[j] >= (RMW+2)'({r_root[j-1], 2'b01});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_m0;
            r_k[0] <= n_k0;
            r_f[0] <= '0;
            for (int j = 1; j <= Q; j++) begin
                r_f[j] <= r_f[j-1] | (Q'(n_step[j][Q+1]) << (Q - j));
                r_k[j] <= r_k[j-1];
            end
            for (int j = 1; j < Q; j++) begin
                r_m[j] <= n_step[j][Q:0];
            end

            r_rad[0]  <= inverf_pkg::RADP_W'({n_w, {inverf_pkg::SQ_SHIFT{1'b0}}});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int j = 1; j <= S; j++) begin
                r_root[j] <= {r_root[j-1][ZW-2:0], n_ge[j]};
            end
            for (int j = 1; j < S; j++) begin
                r_rad[j] <= r_rad[j-1] << 2;
                r_rem[j] <= RMW'(n_ge[j] ? n_cur[j] - (RMW+2)'({r_root[j-1], 2'b01})
                                         : n_cur[j]);
            end
        end
    end

    assign o_z = r_root[S];

endmodule

// ===== sv/inverf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverf_div
// Pipelined restoring divider: round(num * 2^OUT_FRAC_BITS / den), one
// quotient bit per stage, with an overflow flag for quotients past R_W bits.
// ----------------------------------------------------------------------------
module inverf_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [inverf_pkg::H_W-1:0]   i_num,
    input  logic [inverf_pkg::H_W-1:0]   i_den,
    output logic [inverf_pkg::R_W-1:0]   o_quot,
    output logic                         o_sat
);

    localparam int HW  = inverf_pkg::H_W;
    localparam int DQ  = inverf_pkg::R_W;
    localparam int N_W = HW + inverf_pkg::OUT_FRAC_BITS + 1;

    logic [N_W-1:0] r_n;
    logic [HW-1:0]  r_d0;

    logic [HW-1:0]  r_rem [0:DQ-1];
    logic [DQ-1:0]  r_low [0:DQ-1];
    logic [HW-1:0]  r_den [0:DQ-1];
    logic [DQ-1:0]  r_q   [0:DQ];
    logic           r_sat [0:DQ];
    logic [HW:0]    n_cur [1:DQ];
    logic           n_ge  [1:DQ];

    always_comb begin
        for (int j = 1; j <= DQ; j++) begin
            n_cur[j] = {r_rem[j-1], r_low[j-1][DQ-1]};
            n_ge[j]  = n_cur[j] >= (HW+1)'(r_den[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // half the divisor added up front gives round half up
            r_n  <= (N_W'(i_num) << inverf_pkg::OUT_FRAC_BITS) + N_W'(i_den >> 1);
            r_d0 <= i_den;

            r_rem[0] <= HW'(r_n >> DQ);
            r_low[0] <= DQ'(r_n);
            r_den[0] <= r_d0;
            r_sat[0] <= HW'(r_n >> DQ) >= r_d0;
            r_q[0]   <= '0;

            for (int j = 1; j <= DQ; j++) begin
                r_q[j]   <= {r_q[j-1][DQ-2:0], n_ge[j]};
                r_sat[j] <= r_sat[j-1];
            end
            for (int j = 1; j < DQ; j++) begin
                r_rem[j] <= HW'(n_ge[j] ? n_cur[j] - (HW+1)'(r_den[j-1]) : n_cur[j]);
                r_low[j] <= r_low[j-1] << 1;
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign o_quot = r_q[DQ];
    assign o_sat  = r_sat[DQ];

endmodule

// ===== sv/inverse_error_function.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function
// erfinv(x) for signed Q2.23 input, signed Q3.20 result, rational fits for
// the central region and the tails, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  input     i_valid / o_ready, i_x_value    in
//  output    o_valid / i_ready, o_inv_erf,   out
//            o_status
//
//  one word per cycle while the output word is not held; the pipe has the 30 log2
//  squaring stages, the 27 square root stages and the 25 divider stages
//  one pipeline enable: the whole pipe holds while the output word waits
//  synchronous active-low reset clears the side-band words (valid, sign, region, status) only
// ----------------------------------------------------------------------------
module inverse_error_function (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [inverf_pkg::X_W-1:0]     i_x_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [inverf_pkg::R_W-1:0]     o_inv_erf,
    output logic [1:0]                            o_status
);

    localparam int HW    = inverf_pkg::H_W;
    localparam int Q     = inverf_pkg::Q;
    localparam int QT    = inverf_pkg::QT;
    localparam int XW    = inverf_pkg::X_W;
    localparam int RW    = inverf_pkg::R_W;
    localparam int P_Z   = inverf_pkg::TAIL_LAT;
    localparam int P_NT  = P_Z + 3;
    localparam int P_S   = P_NT - 4;
    localparam int P_SEL = P_NT + 1;
    localparam int P_DIV = P_SEL + inverf_pkg::DIV_LAT;
    localparam int P_OUT = P_DIV + 1;

    logic en;

    logic [XW-1:0]          n_ax;
    logic [Q-1:0]           n_u;
    inverf_pkg::t_side      n_side;

    inverf_pkg::t_side      r_side [0:P_OUT];
    logic [Q-1:0]           r_u    [0:P_NT-1];

    logic signed [HW-1:0]   r_s [0:3];
    logic signed [HW-1:0]   r_a1, r_a2, r_n0, r_nc;
    logic signed [HW-1:0]   r_b1, r_b2, r_b3, r_dc;

    logic [inverf_pkg::Z_W-1:0] tail_z;
    logic signed [HW-1:0]   r_z [0:1];
    logic signed [HW-1:0]   r_t1, r_t2, r_nt;
    logic signed [HW-1:0]   r_e1, r_dt1, r_dt;

    logic signed [HW-1:0]   n_num, n_den;
    logic [HW-1:0]          r_mn, r_md;

    logic [RW-1:0]          div_q;
    logic                   div_sat;
    logic                   n_big;
    logic signed [RW-1:0]   n_q;
    logic signed [RW-1:0]   n_res;
    logic signed [RW-1:0]   r_res;

    assign en      = !r_side[P_OUT].valid || i_ready;
    assign o_ready = en;

    // input classification
    always_comb begin
        n_ax          = i_x_value[XW-1] ? XW'(-i_x_value) : XW'(i_x_value);
        n_side.valid  = i_valid;
        n_side.neg    = i_x_value[XW-1];
        if (n_ax > inverf_pkg::ONE_IN) begin
            n_side.status = inverf_pkg::ST_DOMAIN;
        end else if (n_ax == inverf_pkg::ONE_IN) begin
            n_side.status = inverf_pkg::ST_SAT;
        end else begin
            n_side.status = inverf_pkg::ST_OK;
        end
        n_u = (n_side.status == inverf_pkg::ST_OK) ? Q'(n_ax) << inverf_pkg::U_SHIFT : '0;
        n_side.cen = (inverf_pkg::CW'(n_u) * inverf_pkg::CW'(10)) <= inverf_pkg::CEN_LIM;
    end

    inverf_tail u_tail (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (r_u[0]),
        .o_z   (tail_z)
    );

    // pick the region, take magnitudes for the divider
    always_comb begin
        n_num = r_side[P_NT].cen ? r_nc : r_nt;
        n_den = r_side[P_NT].cen ? r_dc : r_dt;
    end

    inverf_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_mn),
        .i_den  (r_md),
        .o_quot (div_q),
        .o_sat  (div_sat)
    );

    always_comb begin
        n_big = div_sat || div_q[RW-1];
        n_q   = $signed({1'b0, div_q[RW-2:0]});
        unique case (r_side[P_DIV].status)
            inverf_pkg::ST_DOMAIN: n_res = '0;
            inverf_pkg::ST_SAT:    n_res = r_side[P_DIV].neg ? inverf_pkg::RMIN
                                                             : inverf_pkg::RMAX;
            default: begin
                if (r_side[P_DIV].neg) begin
                    n_res = n_big ? inverf_pkg::RMIN : -n_q;
                end else begin
                    n_res = n_big ? inverf_pkg::RMAX : n_q;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= P_OUT; i++) begin
                r_side[i] <= '0;
            end
        end else if (en) begin
            r_side[0] <= n_side;
            for (int i = 1; i <= P_OUT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u[0] <= n_u;
            for (int i = 1; i < P_NT; i++) begin
                r_u[i] <= r_u[i-1];
            end

            // central region: x*A(s)/B(s), s = u*u
            r_s[0] <= inverf_pkg::fmul($signed(HW'(r_u[P_S-1])), $signed(HW'(r_u[P_S-1])), Q);
            for (int i = 1; i < 4; i++) begin
                r_s[i] <= r_s[i-1];
            end
            r_a1 <= inverf_pkg::fmul(inverf_pkg::A3, r_s[0], Q) + inverf_pkg::A2;
            r_b1 <= inverf_pkg::fmul(inverf_pkg::B3, r_s[0], Q) + inverf_pkg::B2;
            r_a2 <= inverf_pkg::fmul(r_a1, r_s[1], Q) + inverf_pkg::A1;
            r_b2 <= inverf_pkg::fmul(r_b1, r_s[1], Q) + inverf_pkg::B1;
            r_n0 <= inverf_pkg::fmul(r_a2, r_s[2], Q) + inverf_pkg::A0;
            r_b3 <= inverf_pkg::fmul(r_b2, r_s[2], Q) + inverf_pkg::B0;
            r_nc <= inverf_pkg::fmul($signed(HW'(r_u[P_NT-1])), r_n0, Q);
            r_dc <= inverf_pkg::fmul(r_b3, r_s[3], Q) + inverf_pkg::ONE_Q;

            // tails: C(z)/D(z)
            r_z[0] <= $signed(HW'(tail_z));
            r_z[1] <= r_z[0];
            r_t1  <= inverf_pkg::fmul(inverf_pkg::C3, $signed(HW'(tail_z)), QT)
                     + inverf_pkg::C2;
            r_e1  <= inverf_pkg::fmul(inverf_pkg::D1, $signed(HW'(tail_z)), QT)
                     + inverf_pkg::D0;
            r_t2  <= inverf_pkg::fmul(r_t1, r_z[0], QT) + inverf_pkg::C1;
            r_dt1 <= inverf_pkg::fmul(r_e1, r_z[0], QT) + inverf_pkg::ONE_QT;
            r_nt  <= inverf_pkg::fmul(r_t2, r_z[1], QT) + inverf_pkg::C0;
            r_dt  <= r_dt1;

            r_mn <= n_num[HW-1] ? HW'(-n_num) : HW'(n_num);
            if (n_den == '0) begin
                r_md <= HW'(1);
            end else begin
                r_md <= n_den[HW-1] ? HW'(-n_den) : HW'(n_den);
            end

            r_res <= n_res;
        end
    end

    assign o_valid   = r_side[P_OUT].valid;
    assign o_inv_erf = r_res;
    assign o_status  = 2'(r_side[P_OUT].status);

endmodule

// ===== bench/inverse_error_function_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_error_function_tb
// Self-checking bench for the erfinv pipeline. A bit-exact fixed-point model
// predicts each result word, and a checker compares every output word against
// the oldest prediction. Stimulus is a directed set of boundary arguments and
// then random arguments: central region, tails near one, out-of-range and full
// range. Both handshakes get random gaps and stalls.
// ----------------------------------------------------------------------------
module inverse_error_function_tb;

    localparam int            X_W          = inverf_pkg::X_W;
    localparam int            R_W          = inverf_pkg::R_W;
    localparam int            CLK_HALF     = 4;
    localparam int            IDLE_LIMIT   = 5000;
    localparam int            DRAIN_CYCLES = 150;
    localparam longint        TEN_PLACES   = 64'd10000000000;
    localparam logic [X_W-1:0] UNIT_IN     = X_W'(1) << inverf_pkg::IN_FRAC_BITS;
    // largest magnitude still in the central region: 0.7 in Q2.23, rounded down
    localparam int            CEN_EDGE     = 5872025;

    typedef struct {
        logic signed [R_W-1:0] inv_erf;
        inverf_pkg::t_status   status;
    } t_erf_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [X_W-1:0] i_x_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [R_W-1:0] o_inv_erf;
    logic [1:0]            o_status;

    t_erf_word pending_words[$];
    int        err_count = 0;
    int        words_sent = 0;
    int        words_checked = 0;
    int        idle_cycles = 0;
    bit        no_gaps = 1'b0;

    inverse_error_function i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x_value (i_x_value),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_inv_erf (o_inv_erf),
        .o_status  (o_status)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------------
    function automatic longint dec_fix(input longint unsigned n, input int f);
        return longint'((n / TEN_PLACES) * (64'd1 << f)
                      + (((n % TEN_PLACES) * (64'd1 << f) + TEN_PLACES / 2) / TEN_PLACES));
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint rmul(input longint a, input longint b, input int f);
        longint unsigned p;
        p = (abs64(a) * abs64(b) + (64'd1 << (f - 1))) >> f;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned scaled_quot(input longint n, input longint d);
        longint unsigned mn;
        longint unsigned md;
        mn = abs64(n);
        md = abs64(d);
        if (md == 0) md = 1;
        if (mn > (64'd1 << 34)) mn = 64'd1 << 34;
        return ((mn << inverf_pkg::OUT_FRAC_BITS) + md / 2) / md;
    endfunction

    function automatic longint unsigned central_mag(input longint u);
        longint s;
        longint n;
        longint d;
        s = rmul(u, u, 30);
        n = rmul(rmul(rmul(-dec_fix(64'd1411032044, 30), s, 30)
                      + dec_fix(64'd9266186015, 30),
                 s, 30) - dec_fix(64'd16601283962, 30), s, 30)
          + dec_fix(64'd8862269237, 30);
        d = rmul(rmul(rmul(rmul(dec_fix(64'd119727062, 30), s, 30)
                           - dec_fix(64'd3319823981, 30),
                 s, 30) + dec_fix(64'd14606034035, 30), s, 30)
                 - dec_fix(64'd21350538062, 30),
                 s, 30) + (64'sd1 <<< 30);
        return scaled_quot(rmul(u, n, 30), d);
    endfunction

    function automatic longint unsigned tail_mag(input longint u);
        longint unsigned m;
        longint unsigned k;
        longint unsigned fr;
        longint unsigned lg;
        longint unsigned w;
        longint unsigned ln2;
        longint          z;
        longint          n;
        longint          d;
        m   = longint'((64'sd1 <<< 30) - u);
        k   = 0;
        fr  = 0;
        ln2 = dec_fix(64'd6931471806, 30);
        if (m == 0) m = 1;
        while (m < (64'd1 << 30)) begin
            m <<= 1;
            k++;
        end
        // log2 of the mantissa, one fraction bit per squaring
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m >>= 1;
                fr |= 64'd1 << i;
            end
        end
        lg = ((k + 1) << 30) - fr;
        w  = (lg >> 30) * ln2 + (((lg & ((64'd1 << 30) - 1)) * ln2 + (64'd1 << 29)) >> 30);
        z  = longint'(root64(w << 18));
        n  = rmul(rmul(rmul(dec_fix(64'd18236584577, 24), z, 24)
                       + dec_fix(64'd36087466588, 24),
                  z, 24) - dec_fix(64'd18726741635, 24), z, 24)
           - dec_fix(64'd19942164566, 24);
        d  = rmul(rmul(dec_fix(64'd18184895256, 24), z, 24)
                  + dec_fix(64'd37414629407, 24), z, 24)
           + (64'sd1 <<< 24);
        return scaled_quot(n, d);
    endfunction

    function automatic t_erf_word erfinv_word(input logic signed [X_W-1:0] x);
        t_erf_word       res;
        longint          sx;
        longint unsigned ax;
        longint unsigned q;
        longint          u;
        longint          r;
        sx = x;
        ax = abs64(sx);
        if (ax > UNIT_IN) begin
            res.inv_erf = '0;
            res.status  = inverf_pkg::ST_DOMAIN;
        end else if (ax == UNIT_IN) begin
            res.inv_erf = (sx < 0) ? inverf_pkg::RMIN : inverf_pkg::RMAX;
            res.status  = inverf_pkg::ST_SAT;
        end else begin
            u = longint'(ax << (30 - inverf_pkg::IN_FRAC_BITS));
            if (longint'(u) * 10 <= 7 * (64'sd1 <<< 30)) q = central_mag(u);
            else q = tail_mag(u);
            if (q > (64'd1 << R_W)) q = 64'd1 << R_W;
            r = (sx < 0) ? -longint'(q) : longint'(q);
            if (r > inverf_pkg::RMAX) r = inverf_pkg::RMAX;
            if (r < inverf_pkg::RMIN) r = inverf_pkg::RMIN;
            res.inv_erf = R_W'(r);
            res.status  = inverf_pkg::ST_OK;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic signed [X_W-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        do @(posedge i_clk); while (!o_ready);
        pending_words.push_back(erfinv_word(x));
        words_sent++;
    endtask

    function automatic logic signed [X_W-1:0] with_sign(input int mag_v);
        return $urandom_range(0, 1) ? -X_W'(mag_v) : X_W'(mag_v);
    endfunction

    // stall pattern on the result side, with calm stretches
    always @(posedge i_clk) begin
        if (no_gaps) i_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 75) i_ready <= 1'b1;
        else i_ready <= 1'b0;
    end

    // result checker
    always @(posedge i_clk) begin
        t_erf_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word inv_erf=%0d status=%0d",
                         $time, o_inv_erf, o_status);
                err_count++;
            end else begin
                exp_w = pending_words.pop_front();
                words_checked++;
                if (o_inv_erf !== exp_w.inv_erf) begin
                    $display("%0t: inv_erf expected %0d actual %0d",
                             $time, exp_w.inv_erf, o_inv_erf);
                    err_count++;
                end
                if (o_status !== exp_w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_w.status, o_status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("inverse_error_function test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_boundaries();
        logic signed [X_W-1:0] pts[$];
        pts = '{0, 1, -1, 25'sd8388608, -25'sd8388608, 25'sd8388607, -25'sd8388607,
                25'sd8388609, -25'sd8388609, 25'sd16777215, -25'sd16777216,
                25'sd5872025, -25'sd5872025, 25'sd5872026, -25'sd5872026,
                25'sd4194304, -25'sd4194304, 25'sd8388000, -25'sd8388600,
                25'sd12345678, -25'sd9000000};
        no_gaps = 1'b1;
        foreach (pts[i]) send_word(pts[i]);
        no_gaps = 1'b0;
    endtask

    task automatic test_central(input int count);
        repeat (count) send_word(with_sign($urandom_range(0, CEN_EDGE)));
    endtask

    task automatic test_tails(input int count);
        repeat (count) begin
            if ($urandom_range(0, 2) == 0)
                send_word(with_sign(UNIT_IN - 1 - $urandom_range(0, 2000)));
            else
                send_word(with_sign($urandom_range(CEN_EDGE + 1, UNIT_IN - 1)));
        end
    endtask

    task automatic test_out_of_range(input int count);
        repeat (count) send_word(with_sign($urandom_range(UNIT_IN, 16777215)));
    endtask

    task automatic test_full_range(input int count);
        repeat (count) begin
            no_gaps = ($urandom_range(0, 19) == 0);
            send_word(X_W'($urandom()));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundaries();
        test_central(500);
        test_tails(700);
        test_out_of_range(150);
        test_full_range(580);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d arguments, checked %0d results: central, tails near one,",
                 words_sent, words_checked);
        $display("exact one, out of range and full-range words, with gaps and stalls");
        if (err_count == 0) begin
            $display("inverse_error_function test passed");
        end else begin
            $display("inverse_error_function test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/inverf_pkg.sv
sv/inverf_tail.sv
sv/inverf_div.sv
sv/inverse_error_function.sv
bench/inverse_error_function_tb.sv
